// ===== hdl/mp3fs_pkg.sv =====
// ----------------------------------------------------------------------------
// mp3fs_pkg
// Shared types, constants and the Layer III header check for the frame sync
// finder.
// ----------------------------------------------------------------------------
package mp3fs_pkg;

  // parse phase of the byte stream
  typedef enum logic [2:0] {
    PH_TAG_CHECK = 3'd0,
    PH_TAG_HDR   = 3'd1,
    PH_TAG_SKIP  = 3'd2,
    PH_AID_LEN   = 3'd3,
    PH_AID_SKIP  = 3'd4,
    PH_REFILL    = 3'd5,
    PH_SEARCH    = 3'd6
  } phase_t;

  // result status codes
  typedef enum logic {
    STATUS_FOUND     = 1'b0,
    STATUS_NOT_FOUND = 1'b1
  } status_t;

  // one result item
  typedef struct packed {
    status_t     status;
    logic [31:0] header_word;
    logic [31:0] header_offset;
    logic        free_format;
  } result_t;

  localparam logic [23:0] ID3_MAGIC  = 24'h494433;   // "ID3"
  localparam logic [31:0] AID_MAGIC  = 32'h41694401; // "AiD\1"
  localparam logic [15:0] AID_HDR_LEN = 16'd6;
  localparam int unsigned SYNCSAFE_BITS = 7;

  // valid MPEG Layer III frame header in a 4-byte window
  function automatic logic layer3_header(input logic [31:0] w);
    logic [7:0] b0, b1, b2, b3;
    logic       ok;
    b0 = w[31:24];
    b1 = w[23:16];
    b2 = w[15:8];
    b3 = w[7:0];
    ok = 1'b1;
    if (b0 != 8'hFF)                ok = 1'b0;
    if ((b1 & 8'hE0) != 8'hE0)      ok = 1'b0;
    if ((b1 & 8'h18) == 8'h08)      ok = 1'b0;
    if ((b1 & 8'h06) != 8'h02)      ok = 1'b0;
    if ((b2 & 8'hF0) == 8'hF0)      ok = 1'b0;
    if ((b2 & 8'h0C) == 8'h0C)      ok = 1'b0;
    if ((b3 & 8'h03) == 8'h02)      ok = 1'b0;
    return ok;
  endfunction

endpackage

// ===== hdl/mp3fs_scan.sv =====
// ----------------------------------------------------------------------------
// mp3fs_scan
// Per-byte parser: tag and Album ID skipping, sliding window, header match
// and stream position. One byte per cycle while accept is high, result flagged in the same cycle.
// ----------------------------------------------------------------------------
module mp3fs_scan import mp3fs_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        res_valid,
  output result_t     res
);

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  phase_t                 phase, phase_next;
  logic [31:0]            window, window_next;
  logic [2:0]             phase_count, phase_count_next;
  logic [27:0]            skip_left, skip_left_next;
  logic [OFFSET_BITS-1:0] stream_offset, stream_offset_next;
  logic                   found_done, found_done_next;

  logic [31:0]            win_shift;
  logic [2:0]             count_inc;
  logic                   tag_match;
  logic                   aid_match;
  logic                   check;
  logic                   hit;
  logic [15:0]            aid_len;
  logic [27:0]            skip_dec;
  logic [OFFSET_BITS-1:0] start;
  logic [31:0]            start_out;

  // shared step terms
  assign win_shift = {window[23:0], data_byte};
  assign count_inc = phase_count + 3'd1;
  assign tag_match = (win_shift[31:8] == ID3_MAGIC);
  assign aid_match = (win_shift == AID_MAGIC);
  assign aid_len   = {data_byte, skip_left[7:0]};
  assign skip_dec  = (skip_left != '0) ? skip_left - 28'd1 : skip_left;

  // next state
  always_comb begin
    phase_next         = phase;
    window_next        = window;
    phase_count_next   = phase_count;
    skip_left_next     = skip_left;
    found_done_next    = found_done;
    stream_offset_next = (stream_offset != OFFSET_MAX) ?
                         stream_offset + {{(OFFSET_BITS-1){1'b0}}, 1'b1} : stream_offset;
    if (!found_done) begin
      window_next = win_shift;
      unique case (phase)
        PH_TAG_CHECK, PH_REFILL: begin
          phase_count_next = count_inc;
          if (count_inc >= 3'd4) begin
            phase_count_next = '0;
            if (phase == PH_TAG_CHECK && tag_match) begin
              phase_next     = PH_TAG_HDR;
              skip_left_next = '0;
            end else if (phase == PH_TAG_CHECK && aid_match) begin
              phase_next     = PH_AID_LEN;
              skip_left_next = '0;
            end else begin
              phase_next = PH_SEARCH;
            end
          end
        end
        PH_TAG_HDR: begin
          if (phase_count >= 3'd2) begin
            skip_left_next = {skip_left[27-SYNCSAFE_BITS:0], data_byte[SYNCSAFE_BITS-1:0]};
          end
          phase_count_next = count_inc;
          if (count_inc >= 3'd6) begin
            phase_count_next = '0;
            phase_next = (skip_left_next == '0) ? PH_TAG_CHECK : PH_TAG_SKIP;
          end
        end
        PH_TAG_SKIP: begin
          skip_left_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next       = PH_TAG_CHECK;
            phase_count_next = '0;
          end
        end
        PH_AID_LEN: begin
          if (phase_count == '0) begin
            skip_left_next   = {20'd0, data_byte};
            phase_count_next = 3'd1;
          end else begin
            skip_left_next   = (aid_len > AID_HDR_LEN) ? {12'd0, aid_len - AID_HDR_LEN} : '0;
            phase_count_next = '0;
            phase_next = (aid_len > AID_HDR_LEN) ? PH_AID_SKIP : PH_REFILL;
          end
        end
        PH_AID_SKIP: begin
          skip_left_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next       = PH_REFILL;
            phase_count_next = '0;
          end
        end
        default: begin
          phase_next = PH_SEARCH;
        end
      endcase
      if (hit) begin
        found_done_next = 1'b1;
      end
    end
    // end of stream rearms the parser
    if (last_byte) begin
      phase_next         = PH_TAG_CHECK;
      window_next        = '0;
      phase_count_next   = '0;
      skip_left_next     = '0;
      stream_offset_next = '0;
      found_done_next    = 1'b0;
    end
  end

  // header match flag for this byte
  always_comb begin
    check = 1'b0;
    unique case (phase)
      PH_TAG_CHECK: check = (count_inc >= 3'd4) && !tag_match && !aid_match;
      PH_REFILL:    check = (count_inc >= 3'd4);
      PH_TAG_HDR, PH_TAG_SKIP, PH_AID_LEN, PH_AID_SKIP: check = 1'b0;
      default:      check = 1'b1;
    endcase
    hit = !found_done && check && layer3_header(win_shift);
  end

  // header start position, saturating
  assign start = (stream_offset == OFFSET_MAX) ? OFFSET_MAX :
                 stream_offset - {{(OFFSET_BITS-2){1'b0}}, 2'd3};

  generate
    if (OFFSET_BITS > 32) begin : g_wide
      assign start_out = (|start[OFFSET_BITS-1:32]) ? 32'hFFFF_FFFF : start[31:0];
    end else begin : g_narrow
      assign start_out = 32'(start);
    end
  endgenerate

  // result outputs
  always_comb begin
    res_valid         = accept && (hit || (last_byte && !found_done));
    res.status        = hit ? STATUS_FOUND : STATUS_NOT_FOUND;
    res.header_word   = hit ? win_shift : '0;
    res.header_offset = hit ? start_out : '0;
    res.free_format   = hit && (win_shift[15:12] == 4'd0);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TAG_CHECK;
      window        <= '0;
      phase_count   <= '0;
      skip_left     <= '0;
      stream_offset <= '0;
      found_done    <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      window        <= window_next;
      phase_count   <= phase_count_next;
      skip_left     <= skip_left_next;
      stream_offset <= stream_offset_next;
      found_done    <= found_done_next;
    end
  end

endmodule

// ===== hdl/mp3fs_out_buf.sv =====
// ----------------------------------------------------------------------------
// mp3fs_out_buf
// Result register with a skid entry behind it, so the input side keeps
// moving while one result waits for the receiver.
// ----------------------------------------------------------------------------
module mp3fs_out_buf import mp3fs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    load_out;

  assign load_out = !out_valid || out_ready;
  assign full     = skid_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== hdl/mp3_stream_frame_sync_finder_core.sv =====
// ----------------------------------------------------------------------------
// mp3_stream_frame_sync_finder_core
// Finds the first MPEG Layer III frame header in an audio file byte stream.
// ----------------------------------------------------------------------------
// Input channel: one file byte per transfer (data_byte), last_byte marks the
// final byte of a stream, after which the block rearms for the next stream.
// Leading ID3v2 tags and one Album ID block are skipped, then a 4-byte window
// slides until it holds a valid header.
// Output channel: at most one result per stream: the header word, the offset
// of its first byte and a free-format flag, or status 1 when the stream ends
// without a header. Bytes after a find give nothing until last_byte.
// Throughput: one byte per cycle while in_ready is high; the whole step is one
// pass of parse logic between the accepted byte and the result register.
// Result path: a result goes into the result register, or into the skid entry if that one is held.
// Stall: a result register and one skid entry sit in front of the receiver;
// in_ready drops only while both hold results.
// Reset: clears the parser to the tag check phase and drops both entries.
// ----------------------------------------------------------------------------
module mp3_stream_frame_sync_finder_core import mp3fs_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [31:0] header_word,
  output logic [31:0] header_offset,
  output logic        free_format
);

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    buf_full;
  result_t out_data;

  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;

  // byte parser
  mp3fs_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // result buffering
  mp3fs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign status        = out_data.status;
  assign header_word   = out_data.header_word;
  assign header_offset = out_data.header_offset;
  assign free_format   = out_data.free_format;

  // a full buffer always has a result on the output
  a_full_has_out: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // input stalls only after a result was held back by the receiver
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stall without receiver back-pressure");

  // a found header always starts with the sync byte
  a_found_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FOUND |-> header_word[31:24] == 8'hFF)
    else $error("found result without frame sync");

  // not-found results carry zero payload
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_NOT_FOUND |->
      header_word == 32'd0 && header_offset == 32'd0 && !free_format)
    else $error("not-found result with nonzero payload");

endmodule
